### hdl/pcs_pkg.sv
// shared constants, payload types and controller/datapath command types
// for the streaming correlation block; no dependencies
package pcs_pkg;

  localparam int SAMPLE_W        = 16;
  localparam int RHO_W           = 16;
  localparam int FRAC_W          = 14;
  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int MUL_W           = 64;
  localparam int PROD_W          = 2 * MUL_W;
  localparam int DIV_STEPS       = 2 * FRAC_W + 1;
  localparam int ROOT_W          = FRAC_W + 1;
  localparam int SQRT_STEPS      = ROOT_W;
  localparam int STEP_CNT_W      = $clog2(MUL_W);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x_sample;
    logic signed [SAMPLE_W-1:0] y_sample;
    logic                       last_sample;
  } in_payload_t;

  typedef struct packed {
    logic signed [RHO_W-1:0] rho;
    logic                    degenerate;
    logic                    too_many;
  } out_payload_t;

  typedef enum logic [2:0] {
    P_NSXX   = 3'd0,
    P_SXSX   = 3'd1,
    P_NSYY   = 3'd2,
    P_SYSY   = 3'd3,
    P_NSXY   = 3'd4,
    P_SXSY   = 3'd5,
    P_VXVY   = 3'd6,
    P_COVCOV = 3'd7
  } prod_sel_t;

  typedef struct packed {
    logic      acc_en;
    logic      clear;
    logic      mul_load;
    logic      mul_step;
    logic      mul_store;
    prod_sel_t sel;
    logic      div_load;
    logic      div_step;
    logic      sqrt_load;
    logic      sqrt_step;
    logic      out_load;
  } pcs_cmd_t;

  typedef struct packed {
    logic degen;
  } pcs_status_t;

endpackage

### hdl/pcs_stream_if.sv
// valid/ready channel carrying one payload per transaction
// payload type comes from pcs_pkg at the instance
interface pcs_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### hdl/pearson_correlation_stream.sv
// top level of the streaming correlation block
// depends on pcs_pkg, pcs_stream_if, pcs_ctrl, pcs_datapath
//
//   channel  dir  payload                              transaction
//   in_s     in   x_sample, y_sample, last_sample      one sample pair
//   out_s    out  rho, degenerate, too_many            one result per vector
//
// a pair that is not last is taken with in_ready held high, back to back.
// a last pair starts the shift-add multiplier eight times in a row, then
// the divide and the root, before the result register loads; when a
// variance is zero, it stops after the sx*sy product and skips divide and root.
// the input is held off during that computation; the result register lets
// the next vector stream in while a result waits to be taken.
// rst_n is synchronous and clears the sums, the count and the output valid.
module pearson_correlation_stream #(
  parameter int MAX_SAMPLES = pcs_pkg::MAX_SAMPLES_DEF
) (
  input logic         clk,
  input logic         rst_n,
  pcs_stream_if.sink   in_s,
  pcs_stream_if.source out_s
);

  pcs_pkg::pcs_cmd_t     cmd;
  pcs_pkg::pcs_status_t  status;
  pcs_pkg::in_payload_t  in_data;
  pcs_pkg::out_payload_t out_data;

  assign in_data = in_s.payload;

  pcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_s.valid),
    .in_last   (in_data.last_sample),
    .in_ready  (in_s.ready),
    .out_valid (out_s.valid),
    .out_ready (out_s.ready),
    .status    (status),
    .cmd       (cmd)
  );

  pcs_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .status   (status),
    .out_data (out_data)
  );

  assign out_s.payload = out_data;

endmodule

### hdl/pcs_datapath.sv
// accumulators, shared shift-add multiplier, restoring divider, root unit
// and result register; depends on pcs_pkg
module pcs_datapath #(
  parameter int MAX_SAMPLES = pcs_pkg::MAX_SAMPLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pcs_pkg::pcs_cmd_t     cmd,
  input  pcs_pkg::in_payload_t  in_data,
  output pcs_pkg::pcs_status_t  status,
  output pcs_pkg::out_payload_t out_data
);

  localparam int SW    = pcs_pkg::SAMPLE_W;
  localparam int MW    = pcs_pkg::MUL_W;
  localparam int PW    = pcs_pkg::PROD_W;
  localparam int RW    = pcs_pkg::ROOT_W;
  localparam int QW    = pcs_pkg::DIV_STEPS;
  localparam int N_W   = $clog2(MAX_SAMPLES + 1);
  localparam int SX_W  = SW + N_W;
  localparam int SQ_W  = 2 * SW - 1 + N_W;

  logic [N_W-1:0]         count_r, count_nxt;
  logic signed [SX_W-1:0] sum_x_r, sum_x_nxt, sum_y_r, sum_y_nxt;
  logic signed [SQ_W-1:0] sum_xy_r, sum_xy_nxt;
  logic [SQ_W-1:0]        sum_xx_r, sum_xx_nxt, sum_yy_r, sum_yy_nxt;
  logic                   ovf_r, ovf_nxt;

  logic signed [2*SW-1:0] xy, xx, yy;

  // accumulation
  always_comb begin
    xy = in_data.x_sample * in_data.y_sample;
    xx = in_data.x_sample * in_data.x_sample;
    yy = in_data.y_sample * in_data.y_sample;
    count_nxt  = count_r;
    sum_x_nxt  = sum_x_r;
    sum_y_nxt  = sum_y_r;
    sum_xy_nxt = sum_xy_r;
    sum_xx_nxt = sum_xx_r;
    sum_yy_nxt = sum_yy_r;
    ovf_nxt    = ovf_r;
    if (cmd.clear) begin
      count_nxt  = '0;
      sum_x_nxt  = '0;
      sum_y_nxt  = '0;
      sum_xy_nxt = '0;
      sum_xx_nxt = '0;
      sum_yy_nxt = '0;
      ovf_nxt    = 1'b0;
    end else if (cmd.acc_en) begin
      if (count_r < N_W'(MAX_SAMPLES)) begin
        count_nxt  = count_r + N_W'(1);
        sum_x_nxt  = sum_x_r + {{(SX_W-SW){in_data.x_sample[SW-1]}}, in_data.x_sample};
        sum_y_nxt  = sum_y_r + {{(SX_W-SW){in_data.y_sample[SW-1]}}, in_data.y_sample};
        sum_xy_nxt = sum_xy_r + {{(SQ_W-2*SW){xy[2*SW-1]}}, xy};
        sum_xx_nxt = sum_xx_r + {{(SQ_W-2*SW+1){1'b0}}, xx[2*SW-2:0]};
        sum_yy_nxt = sum_yy_r + {{(SQ_W-2*SW+1){1'b0}}, yy[2*SW-2:0]};
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      sum_x_r  <= '0;
      sum_y_r  <= '0;
      sum_xy_r <= '0;
      sum_xx_r <= '0;
      sum_yy_r <= '0;
      ovf_r    <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      sum_x_r  <= sum_x_nxt;
      sum_y_r  <= sum_y_nxt;
      sum_xy_r <= sum_xy_nxt;
      sum_xx_r <= sum_xx_nxt;
      sum_yy_r <= sum_yy_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  // operand magnitudes for the shared multiplier
  logic [MW-1:0] n64, sxx64, syy64, sx64, sy64, sxy64;
  logic [MW-1:0] sx_mag, sy_mag, sxy_mag, cov_mag;
  logic [MW-1:0] op_a, op_b;
  logic          op_sgn;

  logic [MW-1:0] mul_a_r, mul_a_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic          mul_sgn_r, mul_sgn_nxt;
  logic [MW:0]   step_sum;
  logic [MW-1:0] prod_s64;

  logic [MW-1:0] ta_r, ta_nxt, vx_r, vx_nxt, vy_r, vy_nxt, cov_r, cov_nxt;
  logic [PW-1:0] pp_r, pp_nxt, cc_r, cc_nxt;

  always_comb begin
    n64     = {{(MW-N_W){1'b0}}, count_r};
    sxx64   = {{(MW-SQ_W){1'b0}}, sum_xx_r};
    syy64   = {{(MW-SQ_W){1'b0}}, sum_yy_r};
    sx64    = {{(MW-SX_W){sum_x_r[SX_W-1]}}, sum_x_r};
    sy64    = {{(MW-SX_W){sum_y_r[SX_W-1]}}, sum_y_r};
    sxy64   = {{(MW-SQ_W){sum_xy_r[SQ_W-1]}}, sum_xy_r};
    sx_mag  = sum_x_r[SX_W-1] ? (MW'(0) - sx64) : sx64;
    sy_mag  = sum_y_r[SX_W-1] ? (MW'(0) - sy64) : sy64;
    sxy_mag = sum_xy_r[SQ_W-1] ? (MW'(0) - sxy64) : sxy64;
    cov_mag = cov_r[MW-1] ? (MW'(0) - cov_r) : cov_r;
    op_a    = '0;
    op_b    = '0;
    op_sgn  = 1'b0;
    case (cmd.sel)
      pcs_pkg::P_NSXX: begin
        op_a = n64;
        op_b = sxx64;
      end
      pcs_pkg::P_SXSX: begin
        op_a = sx_mag;
        op_b = sx_mag;
      end
      pcs_pkg::P_NSYY: begin
        op_a = n64;
        op_b = syy64;
      end
      pcs_pkg::P_SYSY: begin
        op_a = sy_mag;
        op_b = sy_mag;
      end
      pcs_pkg::P_NSXY: begin
        op_a   = n64;
        op_b   = sxy_mag;
        op_sgn = sum_xy_r[SQ_W-1];
      end
      pcs_pkg::P_SXSY: begin
        op_a   = sx_mag;
        op_b   = sy_mag;
        op_sgn = sum_x_r[SX_W-1] ^ sum_y_r[SX_W-1];
      end
      pcs_pkg::P_VXVY: begin
        op_a = vx_r;
        op_b = vy_r;
      end
      pcs_pkg::P_COVCOV: begin
        op_a = cov_mag;
        op_b = cov_mag;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // radix-2 shift-add multiplier, multiplier operand in the low half
  always_comb begin
    mul_a_nxt   = mul_a_r;
    prod_nxt    = prod_r;
    mul_sgn_nxt = mul_sgn_r;
    step_sum    = {1'b0, prod_r[PW-1:MW]} + {1'b0, (prod_r[0] ? mul_a_r : MW'(0))};
    if (cmd.mul_load) begin
      mul_a_nxt   = op_a;
      prod_nxt    = {MW'(0), op_b};
      mul_sgn_nxt = op_sgn;
    end else if (cmd.mul_step) begin
      prod_nxt = {step_sum, prod_r[MW-1:1]};
    end
  end

  assign prod_s64 = mul_sgn_r ? (MW'(0) - prod_r[MW-1:0]) : prod_r[MW-1:0];

  always_comb begin
    ta_nxt  = ta_r;
    vx_nxt  = vx_r;
    vy_nxt  = vy_r;
    cov_nxt = cov_r;
    pp_nxt  = pp_r;
    cc_nxt  = cc_r;
    if (cmd.mul_store) begin
      case (cmd.sel)
        pcs_pkg::P_NSXX:   ta_nxt  = prod_s64;
        pcs_pkg::P_SXSX:   vx_nxt  = ta_r - prod_s64;
        pcs_pkg::P_NSYY:   ta_nxt  = prod_s64;
        pcs_pkg::P_SYSY:   vy_nxt  = ta_r - prod_s64;
        pcs_pkg::P_NSXY:   ta_nxt  = prod_s64;
        pcs_pkg::P_SXSY:   cov_nxt = ta_r - prod_s64;
        pcs_pkg::P_VXVY:   pp_nxt  = prod_r;
        pcs_pkg::P_COVCOV: cc_nxt  = prod_r;
        default:           ta_nxt  = ta_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mul_a_r   <= mul_a_nxt;
    prod_r    <= prod_nxt;
    mul_sgn_r <= mul_sgn_nxt;
    ta_r      <= ta_nxt;
    vx_r      <= vx_nxt;
    vy_r      <= vy_nxt;
    cov_r     <= cov_nxt;
    pp_r      <= pp_nxt;
    cc_r      <= cc_nxt;
  end

  assign status.degen = (vx_r == '0) || (vy_r == '0);

  // restoring divide: quotient of cov^2 * 2^28 by vx*vy, one bit a cycle
  logic [PW:0]   rem_r, rem_nxt, rem_diff, rem_keep;
  logic [QW-1:0] quo_r, quo_nxt;
  logic          rem_ge;

  always_comb begin
    rem_ge   = rem_r >= {1'b0, pp_r};
    rem_diff = rem_r - {1'b0, pp_r};
    rem_keep = rem_ge ? rem_diff : rem_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (cmd.div_load) begin
      rem_nxt = {1'b0, cc_r};
      quo_nxt = '0;
    end else if (cmd.div_step) begin
      rem_nxt = {rem_keep[PW-1:0], 1'b0};
      quo_nxt = {quo_r[QW-2:0], rem_ge};
    end
  end

  // bitwise integer square root of the quotient
  logic [RW-1:0]   root_r, root_nxt, rbit_r, rbit_nxt, root_try;
  logic [2*RW-1:0] root_sq;

  always_comb begin
    root_try = root_r | rbit_r;
    root_sq  = root_try * root_try;
    root_nxt = root_r;
    rbit_nxt = rbit_r;
    if (cmd.sqrt_load) begin
      root_nxt = '0;
      rbit_nxt = {1'b1, {(RW-1){1'b0}}};
    end else if (cmd.sqrt_step) begin
      if (root_sq <= {{(2*RW-QW){1'b0}}, quo_r}) begin
        root_nxt = root_try;
      end
      rbit_nxt = {1'b0, rbit_r[RW-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    root_r <= root_nxt;
    rbit_r <= rbit_nxt;
  end

  // result register
  pcs_pkg::out_payload_t out_r, out_nxt;
  logic [pcs_pkg::RHO_W-1:0] rho_pos;

  always_comb begin
    rho_pos = {{(pcs_pkg::RHO_W-RW){1'b0}}, root_r};
    out_nxt = out_r;
    if (cmd.out_load) begin
      out_nxt.too_many   = ovf_r;
      out_nxt.degenerate = status.degen;
      if (status.degen) begin
        out_nxt.rho = '0;
      end else begin
        out_nxt.rho = cov_r[MW-1] ? (pcs_pkg::RHO_W'(0) - rho_pos) : rho_pos;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule

### hdl/pcs_ctrl.sv
// sequencer for accumulation, product chain, divide, root and result
// hand-off; depends on pcs_pkg
module pcs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_last,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  pcs_pkg::pcs_status_t status,
  output pcs_pkg::pcs_cmd_t    cmd
);

  localparam int CW = pcs_pkg::STEP_CNT_W;

  typedef enum logic [8:0] {
    ST_ACC     = 9'b000000001,
    ST_MUL_LD  = 9'b000000010,
    ST_MUL_RUN = 9'b000000100,
    ST_MUL_ST  = 9'b000001000,
    ST_DIV_LD  = 9'b000010000,
    ST_DIV_RUN = 9'b000100000,
    ST_SQ_LD   = 9'b001000000,
    ST_SQ_RUN  = 9'b010000000,
    ST_FIN     = 9'b100000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  pcs_pkg::prod_sel_t sel_r, sel_nxt;
  logic               out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sel_nxt   = sel_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.sel   = sel_r;
    case (state_r)
      ST_ACC: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc_en = 1'b1;
          if (in_last) begin
            sel_nxt   = pcs_pkg::P_NSXX;
            state_nxt = ST_MUL_LD;
          end
        end
      end
      ST_MUL_LD: begin
        cmd.mul_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_MUL_RUN;
      end
      ST_MUL_RUN: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + CW'(1);
        if (cnt_r == CW'(pcs_pkg::MUL_W - 1)) begin
          state_nxt = ST_MUL_ST;
        end
      end
      ST_MUL_ST: begin
        cmd.mul_store = 1'b1;
        if (sel_r == pcs_pkg::P_COVCOV) begin
          state_nxt = ST_DIV_LD;
        end else if (sel_r == pcs_pkg::P_SXSY && status.degen) begin
          state_nxt = ST_FIN;
        end else begin
          sel_nxt   = pcs_pkg::prod_sel_t'(sel_r + 3'd1);
          state_nxt = ST_MUL_LD;
        end
      end
      ST_DIV_LD: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV_RUN;
      end
      ST_DIV_RUN: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + CW'(1);
        if (cnt_r == CW'(pcs_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_SQ_LD;
        end
      end
      ST_SQ_LD: begin
        cmd.sqrt_load = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = ST_SQ_RUN;
      end
      ST_SQ_RUN: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + CW'(1);
        if (cnt_r == CW'(pcs_pkg::SQRT_STEPS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          cmd.clear    = 1'b1;
          state_nxt    = ST_ACC;
        end
      end
      default: begin
        state_nxt = ST_ACC;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_ACC;
      cnt_r       <= '0;
      sel_r       <= pcs_pkg::P_NSXX;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### dv/tb_pearson_correlation_stream.sv
// self-checking bench for pearson_correlation_stream: paired-sample vectors with
// bursty input, a stalling output and a bit-exact correlation predictor
// depends on pcs_pkg, pcs_stream_if and pearson_correlation_stream from hdl
`timescale 1ns / 100ps

module tb_pearson_correlation_stream;

  localparam int MAX_PAIRS = pcs_pkg::MAX_SAMPLES_DEF;
  localparam int ONE_Q14 = 1 << pcs_pkg::FRAC_W;
  localparam int RANDOM_PAIRS = 1850;
  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int DRAIN_CYCLES = 800;
  localparam int HOLD_CYCLES = 4000;

  logic clk;
  logic rst_n;

  pcs_stream_if #(.payload_t(pcs_pkg::in_payload_t)) in_if ();
  pcs_stream_if #(.payload_t(pcs_pkg::out_payload_t)) out_if ();

  pearson_correlation_stream dut (
    .clk  (clk),
    .rst_n(rst_n),
    .in_s (in_if.sink),
    .out_s(out_if.source)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  pcs_pkg::in_payload_t  pending_pairs[$];
  pcs_pkg::out_payload_t expected_rho[$];

  // running sums, wrapping at 64 bits
  bit [63:0] cnt_n, acc_x, acc_y, acc_xy, acc_xx, acc_yy;
  bit        dropped;

  int errors, vectors_done, degen_seen, overflow_seen_cnt, pairs_taken;
  int cycles;

  function automatic pcs_pkg::out_payload_t finish_vector();
    pcs_pkg::out_payload_t r;
    bit [63:0] vx, vy, cov, mag;
    bit [191:0] pv, qv, tv;
    bit neg;
    int lo, hi, mid;
    r = '0;
    r.too_many = dropped;
    vx = cnt_n * acc_xx - acc_x * acc_x;
    vy = cnt_n * acc_yy - acc_y * acc_y;
    cov = cnt_n * acc_xy - acc_x * acc_y;
    if (vx == 0 || vy == 0) begin
      r.degenerate = 1'b1;
    end else begin
      neg = cov[63];
      mag = neg ? (64'd0 - cov) : cov;
      pv = {128'd0, vx} * {128'd0, vy};
      qv = ({128'd0, mag} * {128'd0, mag}) << 28;
      lo = 0;
      hi = ONE_Q14;
      while (lo < hi) begin
        mid = (lo + hi + 1) / 2;
        tv = pv * 192'(longint'(mid) * mid);
        if (tv <= qv) lo = mid;
        else hi = mid - 1;
      end
      r.rho = neg ? pcs_pkg::RHO_W'(-lo) : pcs_pkg::RHO_W'(lo);
    end
    return r;
  endfunction

  task automatic take_pair(input pcs_pkg::in_payload_t p);
    longint sx, sy;
    sx = p.x_sample;
    sy = p.y_sample;
    if (cnt_n < MAX_PAIRS) begin
      cnt_n += 1;
      acc_x += 64'(sx);
      acc_y += 64'(sy);
      acc_xy += 64'(sx * sy);
      acc_xx += 64'(sx * sx);
      acc_yy += 64'(sy * sy);
    end else begin
      dropped = 1'b1;
    end
    if (p.last_sample) begin
      expected_rho.push_back(finish_vector());
      {cnt_n, acc_x, acc_y, acc_xy, acc_xx, acc_yy} = '0;
      dropped = 1'b0;
    end
  endtask

  // driver: bursts of random length separated by random gaps
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (pending_pairs.size() > 0) begin
        in_if.payload <= pending_pairs.pop_front();
        in_if.valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready) begin
      take_pair(in_if.payload);
      pairs_taken <= pairs_taken + 1;
    end
  end

  // receiver: periodically changing random stall pattern, plus one long hold-off
  int hold_left;
  bit hold_done;
  int stall_mode;
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && pairs_taken >= 200) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_mode <= 0;
    end else begin
      if (cycles % 300 == 0) stall_mode <= $urandom_range(0, 2);
      if (hold_left > 0 || (!hold_done && pairs_taken >= 200)) out_if.ready <= 1'b0;
      else if (stall_mode == 0) out_if.ready <= 1'b1;
      else if (stall_mode == 1) out_if.ready <= ($urandom_range(0, 3) != 0);
      else out_if.ready <= ($urandom_range(0, 7) == 0);
    end
  end

  // monitor
  always @(posedge clk) begin
    pcs_pkg::out_payload_t want, got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got = out_if.payload;
      if (expected_rho.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected result rho=%0d degenerate=%0b too_many=%0b",
                                  got.rho, got.degenerate, got.too_many);
      end else begin
        want = expected_rho.pop_front();
        if (got !== want) begin
          errors <= errors + 1;
          if (errors < 10) begin
            $display("mismatch at vector %0d: expected rho=%0d deg=%0b many=%0b",
                     vectors_done, want.rho, want.degenerate, want.too_many);
            $display("  got rho=%0d deg=%0b many=%0b",
                     got.rho, got.degenerate, got.too_many);
          end
        end
        if (want.degenerate) degen_seen <= degen_seen + 1;
        if (want.too_many) overflow_seen_cnt <= overflow_seen_cnt + 1;
      end
      vectors_done <= vectors_done + 1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic add_pair(input int x, input int y, input bit last);
    pcs_pkg::in_payload_t p;
    p.x_sample = pcs_pkg::SAMPLE_W'(x);
    p.y_sample = pcs_pkg::SAMPLE_W'(y);
    p.last_sample = last;
    pending_pairs.push_back(p);
  endtask

  task automatic add_random_vector(input int len);
    int kind, x, y, slope, noise, cx;
    kind = $urandom_range(0, 5);
    slope = $urandom_range(0, 6) - 3;
    noise = 1 << $urandom_range(0, 15);
    cx = $urandom_range(0, 65535) - 32768;
    for (int i = 0; i < len; i++) begin
      x = $urandom_range(0, 65535) - 32768;
      case (kind)
        0: y = $urandom_range(0, 65535) - 32768;
        1: y = (x * slope) / 4 + $urandom_range(0, noise) - noise / 2;
        2: y = -x;
        3: begin
          x = cx;
          y = $urandom_range(0, 65535) - 32768;
        end
        4: begin
          x = (i % 2 == 0) ? -32768 : 32767;
          y = (($urandom_range(0, 1) == 0) ? -32768 : 32767);
        end
        default: begin
          x = $urandom_range(0, 511) - 256;
          y = x + $urandom_range(0, 31) - 16;
        end
      endcase
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      add_pair(x, y, i == len - 1);
    end
  endtask

  initial begin
    int queued;
    clk = 1'b0;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.payload = '0;
    out_if.ready = 1'b0;
    errors = 0;
    cycles = 0;
    pairs_taken = 0;
    vectors_done = 0;
    degen_seen = 0;
    overflow_seen_cnt = 0;
    {cnt_n, acc_x, acc_y, acc_xy, acc_xx, acc_yy} = '0;
    dropped = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: single pair, extremes, perfect and anti correlation, flat data
    add_pair(100, -200, 1'b1);
    add_pair(-32768, -32768, 1'b0);
    add_pair(32767, 32767, 1'b1);
    add_pair(-32768, 32767, 1'b0);
    add_pair(32767, -32768, 1'b1);
    add_pair(5, 1, 1'b0);
    add_pair(5, 2, 1'b0);
    add_pair(5, 3, 1'b1);
    add_pair(1, 7, 1'b0);
    add_pair(2, 7, 1'b0);
    add_pair(3, 7, 1'b1);
    add_pair(0, 0, 1'b0);
    add_pair(0, 0, 1'b1);
    add_pair(1, 3, 1'b0);
    add_pair(2, 1, 1'b0);
    add_pair(3, 4, 1'b0);
    add_pair(-1, -1, 1'b1);

    queued = 0;
    while (queued < RANDOM_PAIRS) begin
      int len;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 20);
      add_random_vector(len);
      queued += len;
    end

    wait (pending_pairs.size() == 0 && !in_if.valid);
    wait (expected_rho.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d vectors checked from %0d sample pairs", vectors_done, pairs_taken);
    $display("%0d flat-variance vectors, %0d with dropped pairs", degen_seen,
             overflow_seen_cnt);
    if (errors == 0 && expected_rho.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
